// ----- design/nns_pkg.sv -----
// Shared types and constants for the nearest-neighbor scaler.
// Used by nns_ctrl, nns_datapath and nearest_neighbor_scaler.
package nns_pkg;

    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int POS_W       = 8;
    localparam int COLOR_W     = 24;
    localparam int ALPHA_W     = 8;
    localparam int PIXEL_W     = COLOR_W + ALPHA_W;
    localparam int QUO_W       = POS_W + 1;
    localparam int DIVD_W      = POS_W + CFG_W;
    localparam int PROD_W      = 2 * CFG_W;
    localparam int STEP_W      = $clog2(QUO_W);
    localparam int CFG_MAX     = (1 << CFG_W) - 1;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [CFG_W-1:0] SRC_SIZE_RST = CFG_W'(256);
    localparam logic [CFG_W-1:0] DST_SIZE_RST = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WRITE,
        S_DIV_X,
        S_DIV_Y,
        S_ADDR,
        S_READ,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic decode;
        logic div_step;
        logic div_next_y;
        logic store_y;
        logic calc_addr;
        logic mem_wr;
        logic mem_rd;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic wr_ok;
        logic rd_ok;
        logic out_busy;
    } t_sts;

endpackage

// ----- design/nearest_neighbor_scaler.sv -----
// Top level of the nearest-neighbor scaler: configuration registers and the
// controller/datapath pair. Depends on nns_pkg, nns_ctrl and nns_datapath.
//
// The block holds a MAX_WIDTH x MAX_HEIGHT frame store of 32-bit pixels (alpha
// over 24-bit RGB), addressed y * src_width + x. A write beat stores one source
// pixel if in range and returns nothing; it passes accept, decode, store write.
// A read beat names a destination pixel and returns one result beat with the
// nearest source pixel, or range_error with zeroed fields. A read passes from
// accept to the output register through two 9-step restoring divisions that
// share one divider, one address multiply and a registered store read.
// Out-of-range reads skip the divisions. The next beat is accepted while a
// result waits in the output register. The store has no reset; reading a pixel
// never written returns undefined data. Write configuration only while idle.
module nearest_neighbor_scaler
    import nns_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_req_type,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    input  logic [COLOR_W-1:0]   i_pixel_color,
    input  logic [ALPHA_W-1:0]   i_pixel_alpha,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [POS_W-1:0]     o_source_x,
    output logic [POS_W-1:0]     o_source_y,
    output logic [COLOR_W-1:0]   o_out_color,
    output logic [ALPHA_W-1:0]   o_out_alpha,
    output logic                 o_range_error
);

    logic [CFG_W-1:0] r_src_width, r_src_height, r_dst_width, r_dst_height;
    t_cmd             cmd;
    t_sts             sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= SRC_SIZE_RST;
            r_src_height <= SRC_SIZE_RST;
            r_dst_width  <= DST_SIZE_RST;
            r_dst_height <= DST_SIZE_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data;
                CFG_DST_HEIGHT: r_dst_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    nns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    nns_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_src_width   (r_src_width),
        .i_src_height  (r_src_height),
        .i_dst_width   (r_dst_width),
        .i_dst_height  (r_dst_height),
        .i_req_type    (i_req_type),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pixel_color (i_pixel_color),
        .i_pixel_alpha (i_pixel_alpha),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_source_x    (o_source_x),
        .o_source_y    (o_source_y),
        .o_out_color   (o_out_color),
        .o_out_alpha   (o_out_alpha),
        .o_range_error (o_range_error)
    );

endmodule

// ----- design/nns_ctrl.sv -----
// Controller state machine for the nearest-neighbor scaler.
// Depends on nns_pkg; drives the commands of nns_datapath.
module nns_ctrl
    import nns_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                step_last;

    assign step_last = (r_step == STEP_W'(QUO_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_step = '0;
                if (!i_sts.is_read) begin
                    n_state = i_sts.wr_ok ? S_WRITE : S_IDLE;
                end else begin
                    n_state = i_sts.rd_ok ? S_DIV_X : S_RESULT;
                end
            end
            S_WRITE: begin
                n_state = S_IDLE;
            end
            S_DIV_X: begin
                if (step_last) begin
                    n_step  = '0;
                    n_state = S_DIV_Y;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DIV_Y: begin
                if (step_last) begin
                    n_step  = '0;
                    n_state = S_ADDR;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_ADDR: begin
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.latch_in  = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
            end
            S_WRITE: begin
                o_cmd.mem_wr = 1'b1;
            end
            S_DIV_X: begin
                o_cmd.div_step   = 1'b1;
                o_cmd.div_next_y = step_last;
            end
            S_DIV_Y: begin
                o_cmd.div_step = 1'b1;
                o_cmd.store_y  = step_last;
            end
            S_ADDR: begin
                o_cmd.calc_addr = 1'b1;
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
            end
            S_RESULT: begin
                o_cmd.load_out = !i_sts.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- design/nns_datapath.sv -----
// Datapath of the nearest-neighbor scaler: item registers, shared restoring
// divider, address multiply, frame store and output register. Depends on nns_pkg.
module nns_datapath
    import nns_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [CFG_W-1:0]   i_src_width,
    input  logic [CFG_W-1:0]   i_src_height,
    input  logic [CFG_W-1:0]   i_dst_width,
    input  logic [CFG_W-1:0]   i_dst_height,
    input  logic               i_req_type,
    input  logic [POS_W-1:0]   i_pos_x,
    input  logic [POS_W-1:0]   i_pos_y,
    input  logic [COLOR_W-1:0] i_pixel_color,
    input  logic [ALPHA_W-1:0] i_pixel_alpha,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [POS_W-1:0]   o_source_x,
    output logic [POS_W-1:0]   o_source_y,
    output logic [COLOR_W-1:0] o_out_color,
    output logic [ALPHA_W-1:0] o_out_alpha,
    output logic               o_range_error
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WLim   = (MAX_WIDTH > CFG_MAX) ? CFG_MAX : MAX_WIDTH;
    localparam int HLim   = (MAX_HEIGHT > CFG_MAX) ? CFG_MAX : MAX_HEIGHT;

    logic [PIXEL_W-1:0] mem [DEPTH];

    logic               r_kind;
    logic [POS_W-1:0]   r_px, r_py;
    logic [COLOR_W-1:0] r_color;
    logic [ALPHA_W-1:0] r_alpha;
    logic               r_err;
    logic [DIVD_W-1:0]  r_rem, r_dsr;
    logic [QUO_W-1:0]   r_q, r_sx, r_sy;
    logic [ADDR_W-1:0]  r_addr;
    logic [PIXEL_W-1:0] r_rd_data;
    logic               r_out_valid;
    logic [POS_W-1:0]   r_o_sx, r_o_sy;
    logic [COLOR_W-1:0] r_o_color;
    logic [ALPHA_W-1:0] r_o_alpha;
    logic               r_o_err;

    logic [CFG_W-1:0]   sw, sh, dw, dh;
    logic               wr_ok, rd_ok, ge;
    logic [DIVD_W-1:0]  n_rem;
    logic [QUO_W-1:0]   n_q;

    assign sw = (i_src_width  > CFG_W'(WLim)) ? CFG_W'(WLim) : i_src_width;
    assign sh = (i_src_height > CFG_W'(HLim)) ? CFG_W'(HLim) : i_src_height;
    assign dw = (i_dst_width  == '0) ? sw : i_dst_width;
    assign dh = (i_dst_height == '0) ? sh : i_dst_height;

    assign wr_ok = (CFG_W'(r_px) < sw) && (CFG_W'(r_py) < sh);
    assign rd_ok = (sw != '0) && (sh != '0) && (dw != '0) && (dh != '0)
                && (CFG_W'(r_px) < dw) && (CFG_W'(r_py) < dh);

    assign ge    = (r_rem >= r_dsr);
    assign n_rem = ge ? (r_rem - r_dsr) : r_rem;
    assign n_q   = {r_q[QUO_W-2:0], ge};

    assign o_sts.is_read  = r_kind;
    assign o_sts.wr_ok    = wr_ok;
    assign o_sts.rd_ok    = rd_ok;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_kind  <= i_req_type;
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_color <= i_pixel_color;
            r_alpha <= i_pixel_alpha;
        end
        if (i_cmd.decode) begin
            r_err  <= !rd_ok;
            r_addr <= ADDR_W'(PROD_W'(r_py) * PROD_W'(sw) + PROD_W'(r_px));
            r_rem  <= DIVD_W'(r_px) * DIVD_W'(sw);
            r_dsr  <= {dw, (QUO_W - 1)'(0)};
            r_q    <= '0;
        end else if (i_cmd.div_next_y) begin
            r_sx   <= n_q;
            r_rem  <= DIVD_W'(r_py) * DIVD_W'(sh);
            r_dsr  <= {dh, (QUO_W - 1)'(0)};
            r_q    <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= n_rem;
            r_dsr  <= r_dsr >> 1;
            r_q    <= n_q;
        end
        if (i_cmd.store_y) begin
            r_sy <= n_q;
        end
        if (i_cmd.calc_addr) begin
            r_addr <= ADDR_W'(PROD_W'(r_sy) * PROD_W'(sw) + PROD_W'(r_sx));
        end
        if (i_cmd.load_out) begin
            r_o_err   <= r_err;
            r_o_sx    <= r_err ? '0 : r_sx[POS_W-1:0];
            r_o_sy    <= r_err ? '0 : r_sy[POS_W-1:0];
            r_o_color <= r_err ? '0 : r_rd_data[COLOR_W-1:0];
            r_o_alpha <= r_err ? '0 : r_rd_data[PIXEL_W-1:COLOR_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem[r_addr] <= {r_alpha, r_color};
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_source_x    = r_o_sx;
    assign o_source_y    = r_o_sy;
    assign o_out_color   = r_o_color;
    assign o_out_alpha   = r_o_alpha;
    assign o_range_error = r_o_err;

endmodule

// ----- sim/tb_nearest_neighbor_scaler.sv -----
// Self-checking testbench for nearest_neighbor_scaler: pixel write and lookup
// beats against a predictor of the frame store and the scaling rule.
// Depends on nns_pkg and the nearest_neighbor_scaler RTL.
module tb_nearest_neighbor_scaler;
    import nns_pkg::*;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam int STORE_DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_BEATS  = 120;
    localparam int PHASE_COUNT  = 12;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic               kind;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [COLOR_W-1:0] color;
        logic [ALPHA_W-1:0] alpha;
    } t_pixel_beat;

    typedef struct packed {
        logic [POS_W-1:0]   sx;
        logic [POS_W-1:0]   sy;
        logic [COLOR_W-1:0] color;
        logic [ALPHA_W-1:0] alpha;
        logic               range_err;
    } t_lookup;

    class nn_lookup_board;
        logic [CFG_W-1:0]   src_w, src_h, dst_w, dst_h;
        bit [PIXEL_W-1:0]   frame [STORE_DEPTH];
        bit                 loaded [STORE_DEPTH];
        t_lookup            expected [$];
        int unsigned        mismatches;

        function new();
            src_w = SRC_SIZE_RST;
            src_h = SRC_SIZE_RST;
            dst_w = DST_SIZE_RST;
            dst_h = DST_SIZE_RST;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_SRC_WIDTH:  src_w = data;
                CFG_SRC_HEIGHT: src_h = data;
                CFG_DST_WIDTH:  dst_w = data;
                CFG_DST_HEIGHT: dst_h = data;
                default: ;
            endcase
        endfunction

        function int unsigned src_cols();
            return (src_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : src_w;
        endfunction

        function int unsigned src_rows();
            return (src_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : src_h;
        endfunction

        function int unsigned dst_cols();
            return (dst_w == 0) ? src_cols() : dst_w;
        endfunction

        function int unsigned dst_rows();
            return (dst_h == 0) ? src_rows() : dst_h;
        endfunction

        function bit map_dest(input int unsigned px, input int unsigned py,
                              output int unsigned sx, output int unsigned sy);
            int unsigned sw, sh, dw, dh;
            sw = src_cols();
            sh = src_rows();
            dw = dst_cols();
            dh = dst_rows();
            sx = 0;
            sy = 0;
            if (sw == 0 || sh == 0 || dw == 0 || dh == 0 || px >= dw || py >= dh)
                return 1'b0;
            sx = px * sw / dw;
            sy = py * sh / dh;
            return (sx < sw && sy < sh);
        endfunction

        function bit target_unloaded(input int unsigned px, input int unsigned py,
                                     output int unsigned sx, output int unsigned sy);
            if (!map_dest(px, py, sx, sy))
                return 1'b0;
            return !loaded[sy * src_cols() + sx];
        endfunction

        function bit note_request(t_pixel_beat b);
            int unsigned sx, sy, addr;
            t_lookup e;
            if (b.kind == REQ_WRITE) begin
                if (b.x >= src_cols() || b.y >= src_rows())
                    return 1'b0;
                addr = b.y * src_cols() + b.x;
                frame[addr] = {b.alpha, b.color};
                loaded[addr] = 1'b1;
                return 1'b1;
            end
            e = '0;
            e.range_err = 1'b1;
            if (map_dest(b.x, b.y, sx, sy)) begin
                addr = sy * src_cols() + sx;
                e.sx = sx[POS_W-1:0];
                e.sy = sy[POS_W-1:0];
                {e.alpha, e.color} = frame[addr];
                e.range_err = 1'b0;
            end
            expected.push_back(e);
            return 1'b1;
        endfunction

        function void check_lookup(t_lookup got);
            t_lookup want;
            if (expected.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = expected.pop_front();
            if (got.sx !== want.sx) begin
                $display("%0t: source_x expected %0d actual %0d", $time, want.sx, got.sx);
                mismatches++;
            end
            if (got.sy !== want.sy) begin
                $display("%0t: source_y expected %0d actual %0d", $time, want.sy, got.sy);
                mismatches++;
            end
            if (got.color !== want.color) begin
                $display("%0t: out_color expected %h actual %h", $time, want.color, got.color);
                mismatches++;
            end
            if (got.alpha !== want.alpha) begin
                $display("%0t: out_alpha expected %h actual %h", $time, want.alpha, got.alpha);
                mismatches++;
            end
            if (got.range_err !== want.range_err) begin
                $display("%0t: range_error expected %b actual %b", $time,
                         want.range_err, got.range_err);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_req_type;
    logic [POS_W-1:0]     i_pos_x;
    logic [POS_W-1:0]     i_pos_y;
    logic [COLOR_W-1:0]   i_pixel_color;
    logic [ALPHA_W-1:0]   i_pixel_alpha;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [POS_W-1:0]     o_source_x;
    logic [POS_W-1:0]     o_source_y;
    logic [COLOR_W-1:0]   o_out_color;
    logic [ALPHA_W-1:0]   o_out_alpha;
    logic                 o_range_error;

    nn_lookup_board lut = new();
    int unsigned    burst_left = 0;
    int unsigned    useful_beats = 0;
    int unsigned    lookups_seen = 0;
    bit             hold_done = 1'b0;

    nearest_neighbor_scaler i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pixel_color (i_pixel_color),
        .i_pixel_alpha (i_pixel_alpha),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_source_x    (o_source_x),
        .o_source_y    (o_source_y),
        .o_out_color   (o_out_color),
        .o_out_alpha   (o_out_alpha),
        .o_range_error (o_range_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_pixel_beat beat(logic kind, int unsigned x, int unsigned y,
                                         logic [COLOR_W-1:0] color, logic [ALPHA_W-1:0] alpha);
        t_pixel_beat b;
        b.kind  = kind;
        b.x     = x[POS_W-1:0];
        b.y     = y[POS_W-1:0];
        b.color = color;
        b.alpha = alpha;
        return b;
    endfunction

    task automatic send_beat(input t_pixel_beat b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_req_type    <= b.kind;
        i_pos_x       <= b.x;
        i_pos_y       <= b.y;
        i_pixel_color <= b.color;
        i_pixel_alpha <= b.alpha;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (lut.note_request(b))
            useful_beats++;
    endtask

    // load the source pixel a lookup would hit if it was never written
    task automatic issue(input t_pixel_beat b);
        int unsigned sx, sy;
        if (b.kind == REQ_READ && lut.target_unloaded(b.x, b.y, sx, sy))
            send_beat(beat(REQ_WRITE, sx, sy, COLOR_W'($urandom), ALPHA_W'($urandom)));
        send_beat(b);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (lut.expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        i_cfg_index <= idx;
        i_cfg_data  <= data[CFG_W-1:0];
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        lut.set_reg(idx, data[CFG_W-1:0]);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input int unsigned sw, input int unsigned sh,
                                 input int unsigned dw, input int unsigned dh);
        settle();
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_DST_WIDTH, dw);
        write_reg(CFG_DST_HEIGHT, dh);
    endtask

    task automatic random_beat();
        t_pixel_beat b;
        int unsigned roll, cols, rows;
        roll    = $urandom_range(0, 99);
        b.color = COLOR_W'($urandom);
        b.alpha = ALPHA_W'($urandom);
        b.x     = POS_W'($urandom);
        b.y     = POS_W'($urandom);
        b.kind  = (roll < 52) ? REQ_WRITE : REQ_READ;
        cols = (b.kind == REQ_WRITE) ? lut.src_cols() : lut.dst_cols();
        rows = (b.kind == REQ_WRITE) ? lut.src_rows() : lut.dst_rows();
        if (cols > DEF_MAX_WIDTH)
            cols = DEF_MAX_WIDTH;
        if (rows > DEF_MAX_HEIGHT)
            rows = DEF_MAX_HEIGHT;
        if ((roll < 45 || (roll >= 52 && roll < 95)) && cols != 0 && rows != 0) begin
            b.x = POS_W'($urandom_range(0, cols - 1));
            b.y = POS_W'($urandom_range(0, rows - 1));
        end
        issue(b);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            lut.check_lookup({o_source_x, o_source_y, o_out_color, o_out_alpha, o_range_error});
            lookups_seen++;
        end
    end

    initial begin : result_side
        int unsigned stall_pct, span;
        i_out_ready = 1'b0;
        forever begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 60;
                default: stall_pct = 90;
            endcase
            span = $urandom_range(20, 150);
            repeat (span) begin
                @(posedge i_clk);
                if (!hold_done && lookups_seen >= HOLD_AFTER) begin
                    hold_done = 1'b1;
                    i_out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin : stimulus
        int unsigned target;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_SRC_WIDTH;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_req_type    = REQ_WRITE;
        i_pos_x       = '0;
        i_pos_y       = '0;
        i_pixel_color = '0;
        i_pixel_alpha = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(beat(REQ_WRITE, 0, 0, 24'h000000, 8'h00));
        issue(beat(REQ_WRITE, 255, 255, 24'hFFFFFF, 8'hFF));
        issue(beat(REQ_WRITE, 255, 0, 24'hFF0000, 8'h80));
        issue(beat(REQ_WRITE, 0, 255, 24'h00FF00, 8'h01));
        issue(beat(REQ_READ, 0, 0, 24'hFFFFFF, 8'hFF));
        issue(beat(REQ_READ, 255, 255, 24'h000000, 8'h00));
        issue(beat(REQ_READ, 255, 0, 24'h000000, 8'h00));
        issue(beat(REQ_READ, 0, 255, 24'h000000, 8'h00));

        apply_setting(16, 8, 32, 3);
        write_reg(CFG_IDX_SPARE, 9'h1FF);
        issue(beat(REQ_WRITE, 16, 0, 24'h123456, 8'h9A));
        issue(beat(REQ_WRITE, 0, 8, 24'h654321, 8'hA9));
        issue(beat(REQ_WRITE, 15, 7, 24'h0000FF, 8'h7F));
        issue(beat(REQ_READ, 32, 0, 24'h000000, 8'h00));
        issue(beat(REQ_READ, 0, 3, 24'h000000, 8'h00));
        issue(beat(REQ_READ, 31, 2, 24'h000000, 8'h00));
        issue(beat(REQ_READ, 30, 2, 24'h000000, 8'h00));

        apply_setting(0, 0, 0, 0);
        issue(beat(REQ_WRITE, 0, 0, 24'hABCDEF, 8'h11));
        issue(beat(REQ_READ, 0, 0, 24'h000000, 8'h00));

        apply_setting(511, 257, 0, 0);
        issue(beat(REQ_READ, 255, 255, 24'h000000, 8'h00));
        issue(beat(REQ_READ, 255, 0, 24'h000000, 8'h00));

        for (int k = 0; k < PHASE_COUNT; k++) begin
            case (k)
                0: apply_setting(256, 256, 0, 0);
                1: apply_setting(1, 1, 0, 0);
                2: apply_setting(1, 1, 256, 256);
                3: apply_setting(256, 256, 256, 256);
                4: apply_setting(511, 300, 1, 511);
                5: apply_setting(0, 5, 9, 0);
                6: apply_setting(7, 200, 511, 3);
                default: apply_setting(
                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 24),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 24),
                    ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 48),
                    ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 48));
            endcase
            target = useful_beats + PHASE_BEATS;
            while (useful_beats < target)
                random_beat();
        end

        settle();
        if (lut.mismatches == 0 && lut.expected.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin : watchdog
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
